### rtl/dqrd_pkg.sv
// Shared types and constants for the doubling quotient/remainder divider.
package dqrd_pkg;

  localparam int unsigned FIELD_W  = 32;
  localparam int unsigned EXT_W    = 64;
  localparam int unsigned S_DATA_W = 64;
  localparam int unsigned M_DATA_W = 64;

  typedef struct packed {
    logic load;
    logic step;
    logic ge;
  } cell_ctrl_t;

endpackage

### rtl/dqrd_cell.sv
// One bit slice of the divider: remainder, quotient and divisor bits with a borrow stage.
module dqrd_cell (
  input  logic                clk,
  input  dqrd_pkg::cell_ctrl_t ctrl,
  input  logic                load_q,
  input  logic                load_d,
  input  logic                sh_in,
  input  logic                q_in,
  input  logic                bin,
  output logic                bout,
  output logic                r,
  output logic                q
);

  logic d;
  logic diff;

  assign diff = sh_in ^ d ^ bin;
  assign bout = (~sh_in & d) | (~(sh_in ^ d) & bin);

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      r <= 1'b0;
      q <= load_q;
      d <= load_d;
    end else if (ctrl.step) begin
      r <= ctrl.ge ? diff : sh_in;
      q <= q_in;
    end
  end

endmodule

### rtl/dqrd_array.sv
// Row of divider cells: remainder shift chain, ripple borrow and restore decision.
module dqrd_array #(
  parameter int unsigned WIDTH = 32
) (
  input  logic             clk,
  input  logic             load,
  input  logic             step,
  input  logic [WIDTH-1:0] dividend_w,
  input  logic [WIDTH-1:0] divisor_w,
  output logic [WIDTH-1:0] quo,
  output logic [WIDTH-1:0] rem
);

  logic [WIDTH-1:0] sh;
  logic [WIDTH-1:0] qin;
  logic [WIDTH:0]   borrow;
  logic             ge;
  dqrd_pkg::cell_ctrl_t ctrl;

  assign borrow[0] = 1'b0;
  assign ge        = rem[WIDTH-1] | ~borrow[WIDTH];
  assign ctrl      = '{load: load, step: step, ge: ge};

  assign sh  = {rem[WIDTH-2:0], quo[WIDTH-1]};
  assign qin = {quo[WIDTH-2:0], ge};

  for (genvar i = 0; i < WIDTH; i++) begin : g_cell
    dqrd_cell u_cell (
      .clk    (clk),
      .ctrl   (ctrl),
      .load_q (dividend_w[i]),
      .load_d (divisor_w[i]),
      .sh_in  (sh[i]),
      .q_in   (qin[i]),
      .bin    (borrow[i]),
      .bout   (borrow[i+1]),
      .r      (rem[i]),
      .q      (quo[i])
    );
  end

endmodule

### rtl/doubling_quotient_remainder_divider.sv
// Top level of the unsigned quotient/remainder divider.
// Usage:
//   Input words arrive on s_tvalid/s_tready/s_tdata: dividend in bits 31:0,
//   divisor in bits 63:32; only the low WIDTH bits of each are used.
//   Results leave on m_tvalid/m_tready/m_tdata/m_tuser: quotient in bits 31:0,
//   remainder in bits 63:32, m_tuser set when the divisor was zero (then the
//   quotient is all ones over WIDTH bits and the remainder is the dividend).
// Timing:
//   One word at a time. The row loads at the accepting edge, then computes the
//   quotient bits one by one, then moves the result to the output register; a
//   new word is taken only after the result has moved out. The row produces
//   one quotient bit per cycle; its borrow ripples across all cells.
//   s_tready is high only while the row is empty.
// Reset:
//   rst clears the sequencer and the output valid; no word is pending after.
// Stalls:
//   A finished result waits in the cell row while the output register is still
//   held by a stalled receiver; the row takes no new word until it moves out.
module doubling_quotient_remainder_divider #(
  parameter int unsigned WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [dqrd_pkg::S_DATA_W-1:0]     s_tdata,   // dividend, divisor
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [dqrd_pkg::M_DATA_W-1:0]     m_tdata,   // quotient_out, remainder_out
  output logic                              m_tuser    // divide_by_zero
);

  localparam int unsigned CNT_W = $clog2(WIDTH + 1);
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]                      state;
  logic [1:0]                      state_next;
  logic [CNT_W-1:0]                cnt;
  logic                            zero_div;
  logic                            load;
  logic                            step;
  logic                            unload;
  logic [dqrd_pkg::EXT_W-1:0]      dividend_ext;
  logic [dqrd_pkg::EXT_W-1:0]      divisor_ext;
  logic [WIDTH-1:0]                dividend_w;
  logic [WIDTH-1:0]                divisor_w;
  logic [WIDTH-1:0]                quo;
  logic [WIDTH-1:0]                rem;
  logic [dqrd_pkg::EXT_W-1:0]      quo_ext;
  logic [dqrd_pkg::EXT_W-1:0]      rem_ext;

  assign dividend_ext = {{(dqrd_pkg::EXT_W - dqrd_pkg::FIELD_W){1'b0}},
                         s_tdata[dqrd_pkg::FIELD_W-1:0]};
  assign divisor_ext  = {{(dqrd_pkg::EXT_W - dqrd_pkg::FIELD_W){1'b0}},
                         s_tdata[2*dqrd_pkg::FIELD_W-1:dqrd_pkg::FIELD_W]};
  assign dividend_w   = dividend_ext[WIDTH-1:0];
  assign divisor_w    = divisor_ext[WIDTH-1:0];

  assign s_tready = (state == ST_IDLE);
  assign load     = s_tvalid && s_tready;
  assign step     = (state == ST_RUN);
  assign unload   = (state == ST_DONE) && (!m_tvalid || m_tready);

  always_comb begin
    quo_ext = '0;
    rem_ext = '0;
    quo_ext[WIDTH-1:0] = quo;
    rem_ext[WIDTH-1:0] = rem;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (load) state_next = ST_RUN;
      ST_RUN:  if (cnt == CNT_W'(1)) state_next = ST_DONE;
      ST_DONE: if (unload) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (unload) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cnt      <= CNT_W'(WIDTH);
      zero_div <= (divisor_w == '0);
    end else if (step) begin
      cnt <= cnt - CNT_W'(1);
    end
    if (unload) begin
      m_tdata <= {rem_ext[dqrd_pkg::FIELD_W-1:0], quo_ext[dqrd_pkg::FIELD_W-1:0]};
      m_tuser <= zero_div;
    end
  end

  dqrd_array #(
    .WIDTH (WIDTH)
  ) u_array (
    .clk        (clk),
    .load       (load),
    .step       (step),
    .dividend_w (dividend_w),
    .divisor_w  (divisor_w),
    .quo        (quo),
    .rem        (rem)
  );

endmodule

### sim/doubling_quotient_remainder_divider_tb.sv
// Stream testbench for the doubling quotient/remainder divider: directed and random divisions.
module doubling_quotient_remainder_divider_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WIDTH      = 32;
  localparam int unsigned LATENCY    = WIDTH + 1;
  localparam int unsigned RAND_WORDS = 1750;
  localparam int unsigned CYCLE_CAP  = 1000000;
  localparam int unsigned CALM_FROM  = 20000;
  localparam int unsigned CALM_TO    = 32000;
  localparam logic [63:0] WMASK      = {64{1'b1}} >> (64 - WIDTH);
  localparam logic [31:0] ALL_ONES   = 32'hFFFF_FFFF;

  typedef struct {
    logic [31:0] quotient;
    logic [31:0] remainder;
    logic        div_zero;
  } quot_rem_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [dqrd_pkg::S_DATA_W-1:0] s_tdata = '0;   // dividend, divisor
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [dqrd_pkg::M_DATA_W-1:0] m_tdata;        // quotient_out, remainder_out
  logic                          m_tuser;        // divide_by_zero

  logic [63:0] dividend_divisor_q[$];
  quot_rem_t   quot_rem_q[$];
  int unsigned cycles = 0;
  int unsigned errors = 0;

  doubling_quotient_remainder_divider #(.WIDTH(WIDTH)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cycles <= cycles + 1;

  function automatic quot_rem_t divide_word(logic [63:0] word);
    logic [63:0] num;
    logic [63:0] den;
    quot_rem_t   res;
    num = {32'd0, word[31:0]} & WMASK;
    den = {32'd0, word[63:32]} & WMASK;
    if (den == 0) begin
      res.quotient  = WMASK[31:0];
      res.remainder = num[31:0];
      res.div_zero  = 1'b1;
    end else begin
      res.quotient  = 32'(num / den);
      res.remainder = 32'(num % den);
      res.div_zero  = 1'b0;
    end
    return res;
  endfunction

  function automatic bit take_break();
    if (cycles >= CALM_FROM && cycles < CALM_TO) return 1'b0;
    return $urandom_range(0, 99) < 33;
  endfunction

  task automatic queue_word(logic [31:0] dividend, logic [31:0] divisor);
    dividend_divisor_q.push_back({divisor, dividend});
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
    end else begin
      if (s_tvalid && s_tready) quot_rem_q.push_back(divide_word(s_tdata));
      if (!s_tvalid || s_tready) begin
        if (dividend_divisor_q.size() > 0 && !take_break()) begin
          s_tdata  <= dividend_divisor_q.pop_front();
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    quot_rem_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= !take_break();
      if (m_tvalid && m_tready) begin
        if (quot_rem_q.size() == 0) begin
          $display("%0t: unexpected word quotient %h remainder %h dz %b", $time,
                   m_tdata[31:0], m_tdata[63:32], m_tuser);
          errors = errors + 1;
        end else begin
          want = quot_rem_q.pop_front();
          if (m_tdata[31:0] !== want.quotient) begin
            $display("%0t: quotient expected %h actual %h", $time, want.quotient,
                     m_tdata[31:0]);
            errors = errors + 1;
          end
          if (m_tdata[63:32] !== want.remainder) begin
            $display("%0t: remainder expected %h actual %h", $time, want.remainder,
                     m_tdata[63:32]);
            errors = errors + 1;
          end
          if (m_tuser !== want.div_zero) begin
            $display("%0t: divide_by_zero expected %b actual %b", $time, want.div_zero,
                     m_tuser);
            errors = errors + 1;
          end
        end
      end
    end
  end

  initial begin
    logic [31:0] dividend;
    logic [31:0] divisor;
    logic [63:0] prod;
    logic [31:0] quo;
    logic [31:0] rem;
    int unsigned pick;
    bit          timed_out;

    // directed: extremes, zero divisor, dividend below divisor, exact division
    queue_word(32'd0, 32'd0);
    queue_word(ALL_ONES, 32'd0);
    queue_word(32'd12345, 32'd0);
    queue_word(32'd0, 32'd1);
    queue_word(ALL_ONES, 32'd1);
    queue_word(ALL_ONES, ALL_ONES);
    queue_word(ALL_ONES - 1, ALL_ONES);
    queue_word(32'd1, ALL_ONES);
    queue_word(32'd0, ALL_ONES);
    queue_word(32'd5, 32'd7);
    queue_word(32'd7, 32'd7);
    queue_word(32'd100, 32'd7);
    queue_word(32'd1, 32'd1);
    queue_word(32'h8000_0000, 32'd1);
    queue_word(32'h8000_0000, 32'h8000_0000);
    queue_word(32'h7FFF_FFFF, 32'h8000_0000);
    queue_word(ALL_ONES, 32'h8000_0000);
    queue_word(ALL_ONES, 32'd2);
    queue_word(ALL_ONES, 32'd3);
    queue_word(32'h0001_0000, 32'h0000_0100);
    queue_word(32'hAAAA_AAAA, 32'h5555_5555);
    queue_word(32'h5555_5555, 32'hAAAA_AAAA);
    queue_word(32'd1000000, 32'd1000);

    repeat (RAND_WORDS) begin
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        dividend = $urandom >> $urandom_range(0, 31);
        divisor  = 32'd0;
      end else if (pick < 25) begin
        dividend = $urandom;
        divisor  = $urandom;
      end else if (pick < 55) begin
        dividend = $urandom >> $urandom_range(0, 31);
        divisor  = $urandom >> $urandom_range(0, 31);
      end else if (pick < 80) begin
        divisor = ($urandom >> $urandom_range(0, 31)) | 32'd1;
        quo     = $urandom >> $urandom_range(0, 31);
        if (quo > ALL_ONES / divisor) quo = ALL_ONES / divisor;
        prod = 64'(quo) * 64'(divisor);
        rem  = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom % divisor;
        if (64'(rem) > 64'(ALL_ONES) - prod) rem = 32'(64'(ALL_ONES) - prod);
        dividend = 32'(prod + 64'(rem));
      end else begin
        divisor  = ($urandom >> $urandom_range(0, 31)) | 32'd1;
        dividend = $urandom % divisor;
      end
      queue_word(dividend, divisor);
    end

    rst = 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while ((dividend_divisor_q.size() > 0 || s_tvalid || quot_rem_q.size() > 0)
           && cycles < CYCLE_CAP)
      @(posedge clk);
    timed_out = cycles >= CYCLE_CAP;

    if (timed_out) begin
      $display("%0t: timeout with %0d words outstanding", $time, quot_rem_q.size());
      $display("** doubling_quotient_remainder_divider: FAILED **");
    end else begin
      repeat (3 * LATENCY) @(posedge clk);
      if (errors == 0 && quot_rem_q.size() == 0) begin
        $display("** doubling_quotient_remainder_divider: PASSED **");
      end else begin
        $display("** doubling_quotient_remainder_divider: FAILED **");
      end
    end
    $finish;
  end

endmodule
